[src/circular_double_ended_queue_assert.svh]
// Assertion macros for the circular deque RTL.
// Included by the top level; no other dependencies.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");
`else
`define CDEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/cdeq_pkg.sv]
// Shared types and codes for the circular deque.
// Used by cdeq_ctrl, cdeq_dpath and the top level.
package cdeq_pkg;

	localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
	localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
	localparam logic [2:0] OP_POP_HEAD  = 3'd2;
	localparam logic [2:0] OP_POP_TAIL  = 3'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic               is_full;
		logic               is_empty;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_read;
	} sts_t;

endpackage

[src/cdeq_dpath.sv]
// Datapath of the circular deque: pointers, empty flag, entry memory, result register.
// Depends on cdeq_pkg.
module cdeq_dpath #(
	parameter int CAPACITY = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cdeq_pkg::cmd_t  cmd,
	input  cdeq_pkg::req_t  request,
	output cdeq_pkg::sts_t  sts,
	output cdeq_pkg::rsp_t  result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

	logic [31:0]   mem [CAPACITY];
	logic [2:0]    op_q;
	logic [31:0]   word_q;
	logic [IW-1:0] head_q, tail_q;
	logic          empty_q;
	logic [31:0]   rd_q;
	cdeq_pkg::rsp_t rsp_q;

	logic          is_push, is_pop, full;
	logic [IW-1:0] head_n, tail_n, wr_addr, rd_addr;
	logic          empty_n, full_n, wr_en, rd_en;
	logic [1:0]    status_n;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	assign is_push = (op_q == cdeq_pkg::OP_PUSH_HEAD) || (op_q == cdeq_pkg::OP_PUSH_TAIL);
	assign is_pop  = (op_q == cdeq_pkg::OP_POP_HEAD) || (op_q == cdeq_pkg::OP_POP_TAIL);
	assign full    = !empty_q && (wrap_inc(tail_q) == head_q);

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		empty_n  = empty_q;
		status_n = cdeq_pkg::ST_DONE;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		rd_en    = 1'b0;
		rd_addr  = (op_q == cdeq_pkg::OP_POP_HEAD) ? head_q : tail_q;
		if (is_push) begin
			if (full) begin
				status_n = cdeq_pkg::ST_OVERFLOW;
			end else begin
				wr_en = 1'b1;
				if (empty_q) begin
					head_n  = '0;
					tail_n  = '0;
					empty_n = 1'b0;
					wr_addr = '0;
				end else if (op_q == cdeq_pkg::OP_PUSH_HEAD) begin
					head_n  = wrap_dec(head_q);
					wr_addr = head_n;
				end else begin
					tail_n  = wrap_inc(tail_q);
					wr_addr = tail_n;
				end
			end
		end else if (is_pop) begin
			if (empty_q) begin
				status_n = cdeq_pkg::ST_UNDERFLOW;
			end else begin
				rd_en = 1'b1;
				// last entry leaves: return to the empty layout
				if (head_q == tail_q) begin
					head_n  = '0;
					tail_n  = '0;
					empty_n = 1'b1;
				end else if (op_q == cdeq_pkg::OP_POP_HEAD) begin
					head_n = wrap_inc(head_q);
				end else begin
					tail_n = wrap_dec(tail_q);
				end
			end
		end
		full_n = !empty_n && (wrap_inc(tail_n) == head_n);
	end

	assign sts.needs_read = is_pop && !empty_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (cmd.exec && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			empty_q <= empty_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (cmd.finish) begin
			// pointers already advanced during exec
			rsp_q.data_out <= rd_q;
			rsp_q.status   <= cdeq_pkg::ST_DONE;
			rsp_q.is_full  <= full;
			rsp_q.is_empty <= empty_q;
		end else if (cmd.exec && !sts.needs_read) begin
			rsp_q.data_out <= '0;
			rsp_q.status   <= status_n;
			rsp_q.is_full  <= full_n;
			rsp_q.is_empty <= empty_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= request.operation;
			word_q <= request.data_in;
		end
	end

	assign result = rsp_q;

endmodule

[src/cdeq_ctrl.sv]
// Controller of the circular deque: sequences capture, execute and memory read.
// Depends on cdeq_pkg.
module cdeq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cdeq_pkg::sts_t sts,
	output cdeq_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t state_q;
	logic   busy_q, done_q;

	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.finish  = (state_q == S_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					// successful pops go on to S_READ for the registered memory read
					if (sts.needs_read) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[src/circular_double_ended_queue.sv]
// Circular deque top level. A push, query or failed op runs through S_EXEC; a successful pop
// also passes through S_READ for the entry memory's registered read port (done high one cycle).
// A new request is taken only once the last result is out. The receiver cannot stall:
// results are never held off.
// Reset (arst_n low) empties the queue at once; entry contents are not cleared.
// Depends on cdeq_pkg, cdeq_ctrl, cdeq_dpath and the assertion header.
`include "circular_double_ended_queue_assert.svh"

module circular_double_ended_queue #(
	parameter int CAPACITY = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cdeq_pkg::req_t request,
	output logic           done,
	output cdeq_pkg::rsp_t result
);

	cdeq_pkg::cmd_t cmd;
	cdeq_pkg::sts_t sts;

	cdeq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cdeq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.sts     (sts),
		.result  (result)
	);

	`CDEQ_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`CDEQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`CDEQ_ASSERT_IMPL(a_ovf_full, clk, arst_n, done && (result.status == cdeq_pkg::ST_OVERFLOW), result.is_full)
	`CDEQ_ASSERT_IMPL(a_udf_empty, clk, arst_n, done && (result.status == cdeq_pkg::ST_UNDERFLOW), result.is_empty)
	`CDEQ_ASSERT_IMPL(a_data_ok, clk, arst_n, done && (result.data_out != 0), result.status == cdeq_pkg::ST_DONE)

endmodule

[bench/circular_double_ended_queue_tb.sv]
// Self-checking bench for the circular deque: predicts every result from its own deque
// model and compares each strobed result field by field. Depends on cdeq_pkg and the RTL.
`timescale 1ns / 100ps

module circular_double_ended_queue_tb;

	localparam int DEPTH = 8;
	localparam time PERIOD = 4;
	localparam logic [2:0] OP_QUERY    = 3'd4;
	localparam logic [2:0] OP_RSVD_LO  = 3'd5;
	localparam logic [2:0] OP_RSVD_HI  = 3'd7;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
	localparam int BLOCKS = 16;
	localparam int BLOCK_LEN = 40;

	// Deque model plus the queue of results it still owes.
	class deque_scoreboard;
		logic signed [31:0] words[DEPTH];
		int head_idx;
		int tail_idx;
		bit vacant;
		cdeq_pkg::rsp_t owed[$];
		int errors;

		function new();
			head_idx = 0;
			tail_idx = 0;
			vacant = 1'b1;
			errors = 0;
		endfunction

		function bit at_capacity();
			return !vacant && ((tail_idx + 1) % DEPTH == head_idx);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_request(cdeq_pkg::req_t req);
			cdeq_pkg::rsp_t want;
			want = '0;
			want.status = cdeq_pkg::ST_DONE;
			case (req.operation)
				cdeq_pkg::OP_PUSH_HEAD, cdeq_pkg::OP_PUSH_TAIL: begin
					if (at_capacity()) begin
						want.status = cdeq_pkg::ST_OVERFLOW;
					end else begin
						if (vacant) begin
							head_idx = 0;
							tail_idx = 0;
							vacant = 1'b0;
						end else if (req.operation == cdeq_pkg::OP_PUSH_HEAD) begin
							head_idx = (head_idx + DEPTH - 1) % DEPTH;
						end else begin
							tail_idx = (tail_idx + 1) % DEPTH;
						end
						if (req.operation == cdeq_pkg::OP_PUSH_HEAD)
							words[head_idx] = req.data_in;
						else
							words[tail_idx] = req.data_in;
					end
				end
				cdeq_pkg::OP_POP_HEAD, cdeq_pkg::OP_POP_TAIL: begin
					if (vacant) begin
						want.status = cdeq_pkg::ST_UNDERFLOW;
					end else begin
						want.data_out = (req.operation == cdeq_pkg::OP_POP_HEAD) ?
							words[head_idx] : words[tail_idx];
						// last entry gone: both pointers go back to zero
						if (head_idx == tail_idx) begin
							vacant = 1'b1;
							head_idx = 0;
							tail_idx = 0;
						end else if (req.operation == cdeq_pkg::OP_POP_HEAD) begin
							head_idx = (head_idx + 1) % DEPTH;
						end else begin
							tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
						end
					end
				end
				default: begin
				end
			endcase
			want.is_full = at_capacity();
			want.is_empty = vacant;
			owed.push_back(want);
		endfunction

		function void check_result(cdeq_pkg::rsp_t got);
			cdeq_pkg::rsp_t want;
			if (owed.size() == 0) begin
				$error("result with none outstanding: data_out %0d status %0d",
					got.data_out, got.status);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.data_out !== want.data_out) begin
				$error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.is_full !== want.is_full) begin
				$error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cdeq_pkg::req_t request = '0;
	logic done;
	cdeq_pkg::rsp_t result;

	deque_scoreboard board = new();

	circular_double_ended_queue #(
		.CAPACITY(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	// Hold start high across back-to-back transfers; drop it only for a gap.
	task automatic issue(input logic [2:0] op, input logic signed [31:0] word,
		input bit idle_ok);
		int gap;
		gap = idle_ok ? $urandom_range(7, 0) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= '{operation: op, data_in: word};
		do @(posedge clk); while (busy);
		board.note_request(request);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [2:0] pick_op(int push_pct);
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 4)
			return OP_QUERY;
		if (roll < 8)
			return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
		if (roll - 8 < push_pct * 92 / 100)
			return $urandom_range(1, 0) ? cdeq_pkg::OP_PUSH_HEAD : cdeq_pkg::OP_PUSH_TAIL;
		return $urandom_range(1, 0) ? cdeq_pkg::OP_POP_HEAD : cdeq_pkg::OP_POP_TAIL;
	endfunction

	initial begin
		int push_pct;
		bit idle_ok;
		int wait_left;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: query and both underflows
		issue(OP_QUERY, $urandom, 1'b0);
		issue(cdeq_pkg::OP_POP_HEAD, $urandom, 1'b0);
		issue(cdeq_pkg::OP_POP_TAIL, $urandom, 1'b1);
		// push into empty, then pop the only entry
		issue(cdeq_pkg::OP_PUSH_HEAD, WORD_MIN, 1'b0);
		issue(cdeq_pkg::OP_POP_TAIL, $urandom, 1'b0);
		issue(cdeq_pkg::OP_PUSH_TAIL, WORD_MAX, 1'b0);
		issue(cdeq_pkg::OP_PUSH_HEAD, -32'sd1, 1'b1);
		issue(cdeq_pkg::OP_PUSH_TAIL, 32'sd0, 1'b0);
		// fill from both ends so the head wraps below zero
		for (int i = 0; i < 5; i++)
			issue(i[0] ? cdeq_pkg::OP_PUSH_TAIL : cdeq_pkg::OP_PUSH_HEAD, $urandom, 1'b0);
		issue(cdeq_pkg::OP_PUSH_HEAD, $urandom, 1'b1);
		issue(cdeq_pkg::OP_PUSH_TAIL, $urandom, 1'b0);
		for (logic [2:0] op = OP_RSVD_LO; op <= OP_RSVD_HI && op >= OP_RSVD_LO; op++)
			issue(op, $urandom, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			issue(i[0] ? cdeq_pkg::OP_POP_TAIL : cdeq_pkg::OP_POP_HEAD, $urandom, i[1]);

		for (int b = 0; b < BLOCKS; b++) begin
			case (b % 3)
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			idle_ok = ($urandom_range(3, 0) != 0);
			if (b == BLOCKS / 2)
				drain();
			for (int i = 0; i < BLOCK_LEN; i++)
				issue(pick_op(push_pct), $urandom, idle_ok);
		end
		start <= 1'b0;

		wait_left = 200;
		while (board.pending() != 0 && wait_left > 0) begin
			@(posedge clk);
			wait_left--;
		end
		if (board.pending() != 0) begin
			$error("%0d results never arrived", board.pending());
			board.errors++;
		end
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("circular_double_ended_queue: match");
		else
			$display("circular_double_ended_queue: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("circular_double_ended_queue: mismatch");
		$finish;
	end

endmodule
